>>> rtl/fdpo_pkg.sv
// ----------------------------------------------------------------------------
// fdpo_pkg
// Types and constants shared by the fault-density page-order policy block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package fdpo_pkg;

    localparam int PID_W    = 22;
    localparam int ADDR_W   = 48;
    localparam int REGION_SHIFT = 21;
    localparam int REGION_W = ADDR_W - REGION_SHIFT;
    localparam int KEY_W    = PID_W + REGION_W;
    localparam int HASH_W   = PID_W + 7;
    localparam int CNT_W    = 8;
    localparam int ORDER_W  = 4;
    localparam int FRAG_W   = 7;
    localparam int BLK_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] WARM_COUNT = 8'd4;
    localparam logic [CNT_W-1:0] HOT_COUNT  = 8'd32;
    localparam logic [CNT_W-1:0] VHOT_COUNT = 8'd128;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 8'd255;
    localparam logic [CNT_W-1:0] COUNT_ONE  = 8'd1;
    localparam logic [FRAG_W-1:0] FRAG_CAP  = 7'd90;

    localparam logic [ORDER_W-1:0] ORDER_4K   = 4'd0;
    localparam logic [ORDER_W-1:0] ORDER_16K  = 4'd2;
    localparam logic [ORDER_W-1:0] ORDER_64K  = 4'd4;
    localparam logic [ORDER_W-1:0] ORDER_2M   = 4'd9;

    typedef enum logic [1:0] {
        ST_EVALUATED = 2'd0,
        ST_RECLAIM   = 2'd1,
        ST_EXCLUDED  = 2'd2,
        ST_FIRST     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAG_INDEX   = 3'd0,
        REG_FREE_2MB     = 3'd1,
        REG_FREE_64KB    = 3'd2,
        REG_FREE_16KB    = 3'd3,
        REG_MIN_FREE_2MB = 3'd4,
        REG_MIN_FREE_64KB = 3'd5,
        REG_MIN_FREE_16KB = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    typedef struct packed {
        logic [PID_W-1:0]  proc_id;
        logic [ADDR_W-1:0] fault_address;
        logic              grows_down;
        logic              is_exec;
        logic              is_file;
        logic              reclaim_active;
    } t_fault_item;

    typedef struct packed {
        logic [ORDER_W-1:0] page_order;
        logic [1:0]         status;
        logic               promoted;
        logic               guard_limited;
        logic [CNT_W-1:0]   region_faults;
    } t_policy_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [BLK_W-1:0]     data;
    } t_cfg_write;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_region_entry;

    function automatic logic [ORDER_W-1:0] count_to_order(input logic [CNT_W-1:0] c);
        logic [ORDER_W-1:0] o;
        if (c >= VHOT_COUNT) begin
            o = ORDER_2M;
        end else if (c >= HOT_COUNT) begin
            o = ORDER_64K;
        end else if (c >= WARM_COUNT) begin
            o = ORDER_16K;
        end else begin
            o = ORDER_4K;
        end
        return o;
    endfunction

endpackage

>>> rtl/fdpo_if.sv
// ----------------------------------------------------------------------------
// fdpo channel interfaces
// Valid/ready channels for fault items, policy results and register writes.
// ----------------------------------------------------------------------------
interface fdpo_fault_if import fdpo_pkg::*; ();
    logic        valid;
    logic        ready;
    t_fault_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface fdpo_result_if import fdpo_pkg::*; ();
    logic           valid;
    logic           ready;
    t_policy_result item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface fdpo_cfg_if import fdpo_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_write item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/fault_density_page_order_policy.sv
// ----------------------------------------------------------------------------
// fault_density_page_order_policy
// Chooses a page order for each fault from per-region fault density and
// free-block guards.
// ----------------------------------------------------------------------------
// The cycle a fault item is accepted reads the direct-mapped region table
// (one synchronous single-port memory); then, once the result register is
// free, the key is compared, the count updated, the entry written back
// (unless reclaim, grows-down or exec) and the result register loaded. The
// next item is taken while a result still waits on o_result. After reset a
// clearing pass writes every table entry once, during which no fault item
// is accepted; register writes are taken at any time. TABLE_ENTRIES must be
// a power of two; the table index is the low bits of the region/process hash.
// ----------------------------------------------------------------------------
module fault_density_page_order_policy import fdpo_pkg::*; #(
    parameter int TABLE_ENTRIES = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fdpo_fault_if.sink          i_fault,
    fdpo_result_if.source       o_result,
    fdpo_cfg_if.sink            i_cfg
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // configuration registers
    logic [FRAG_W-1:0] r_frag;
    logic [BLK_W-1:0]  r_free_2m, r_free_64k, r_free_16k;
    logic [BLK_W-1:0]  r_min_2m, r_min_64k, r_min_16k;

    // control
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_idx;
    logic               r_out_valid;
    t_policy_result     r_out;

    // item held for the lookup cycle
    t_fault_item        r_item;
    logic [IDX_W-1:0]   r_idx;

    // region table
    t_region_entry      r_table [TABLE_ENTRIES];
    t_region_entry      r_rd;

    logic               in_take, out_take, load_out;
    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    t_region_entry      tbl_wdata;
    logic [HASH_W-1:0]  hash;
    logic [IDX_W-1:0]   in_idx;
    logic [KEY_W-1:0]   cur_key;
    logic               hit, skip;
    logic [CNT_W-1:0]   n_count;
    logic [ORDER_W-1:0] ideal, order;
    t_policy_result     n_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag     <= '0;
            r_free_2m  <= '0;
            r_free_64k <= '0;
            r_free_16k <= '0;
            r_min_2m   <= '0;
            r_min_64k  <= '0;
            r_min_16k  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.item.index)
                REG_FRAG_INDEX:    r_frag     <= i_cfg.item.data[FRAG_W-1:0];
                REG_FREE_2MB:      r_free_2m  <= i_cfg.item.data;
                REG_FREE_64KB:     r_free_64k <= i_cfg.item.data;
                REG_FREE_16KB:     r_free_16k <= i_cfg.item.data;
                REG_MIN_FREE_2MB:  r_min_2m   <= i_cfg.item.data;
                REG_MIN_FREE_64KB: r_min_64k  <= i_cfg.item.data;
                REG_MIN_FREE_16KB: r_min_16k  <= i_cfg.item.data;
                default: ;
            endcase
        end
    end

    // index hash: region ^ (pid << 7) ^ (pid >> 6)
    assign hash = {{(HASH_W-REGION_W){1'b0}}, i_fault.item.fault_address[ADDR_W-1:REGION_SHIFT]}
                ^ {i_fault.item.proc_id, 7'b0}
                ^ {{(HASH_W-PID_W+6){1'b0}}, i_fault.item.proc_id[PID_W-1:6]};
    assign in_idx = hash[IDX_W-1:0];

    assign out_take = o_result.valid & o_result.ready;
    assign in_take  = i_fault.valid & i_fault.ready;
    assign load_out = (r_state == S_LOOKUP) && (!r_out_valid || o_result.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (&r_clr_idx) n_state = S_IDLE;
            S_IDLE:   if (i_fault.valid) n_state = S_LOOKUP;
            S_LOOKUP: if (load_out) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        i_fault.ready = 1'b0;
        tbl_we        = 1'b0;
        tbl_waddr     = r_idx;
        tbl_wdata     = '{valid: 1'b1, key: cur_key, count: n_count};
        case (r_state)
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr_idx;
                tbl_wdata = '0;
            end
            S_IDLE: begin
                i_fault.ready = 1'b1;
            end
            S_LOOKUP: begin
                tbl_we = load_out && !skip;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table: write back or clear, read on accept
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
        if (in_take) begin
            r_rd <= r_table[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_fault.item;
            r_idx  <= in_idx;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    // lookup, count update and guards
    assign cur_key = {r_item.proc_id, r_item.fault_address[ADDR_W-1:REGION_SHIFT]};
    assign skip    = r_item.reclaim_active | r_item.grows_down | r_item.is_exec;
    assign hit     = r_rd.valid && (r_rd.key == cur_key);

    always_comb begin
        if (!hit) begin
            n_count = COUNT_ONE;
        end else if (r_rd.count == COUNT_MAX) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = r_rd.count + COUNT_ONE;
        end

        ideal = count_to_order(n_count);
        if (r_item.is_file && ideal > ORDER_64K) begin
            ideal = ORDER_64K;
        end

        order = ideal;
        if (order >= ORDER_2M && r_free_2m < r_min_2m) begin
            order = ORDER_64K;
        end
        if (order >= ORDER_64K && r_free_64k < r_min_64k) begin
            order = ORDER_16K;
        end
        if (order >= ORDER_16K && r_free_16k < r_min_16k) begin
            order = ORDER_4K;
        end
        if (r_frag > FRAG_CAP && order > ORDER_16K) begin
            order = ORDER_16K;
        end

        n_out = '0;
        if (r_item.reclaim_active) begin
            n_out.status = ST_RECLAIM;
        end else if (r_item.grows_down || r_item.is_exec) begin
            n_out.status = ST_EXCLUDED;
        end else if (!hit) begin
            n_out.status        = ST_FIRST;
            n_out.region_faults = COUNT_ONE;
        end else begin
            n_out.page_order    = order;
            n_out.status        = ST_EVALUATED;
            n_out.promoted      = (order != ORDER_4K);
            n_out.guard_limited = (order < ideal);
            n_out.region_faults = n_count;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.item  = r_out;

endmodule
